// File: hdl/multichannel_stereo_sample_mixer_core_assert.svh
// Assertion macros for the stereo sample mixer.
// Included by files that carry concurrent assertions; needs no package.
`ifndef MULTICHANNEL_STEREO_SAMPLE_MIXER_CORE_ASSERT_SVH
`define MULTICHANNEL_STEREO_SAMPLE_MIXER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Implication in the same cycle.
`define MSSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication into the next cycle.
`define MSSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MSSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/mssm_pkg.sv
// Shared types and constants of the stereo sample mixer.
// Used by every module of the block but mssm_ram; depends on nothing.
package mssm_pkg;

    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_GAIN  = 3'd3;
    localparam logic [2:0] REQ_TICK  = 3'd4;

    localparam logic [9:0] MUSIC_SCALE_RESET = 10'd256;
    localparam logic [9:0] MUSIC_SCALE_MAX   = 10'd512;
    localparam logic [7:0] SEP_MAX           = 8'd254;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [3:0]         voice;
        logic [15:0]        address;
        logic signed [15:0] sample_value;
        logic [16:0]        clip_length;
        logic [6:0]         volume;
        logic [7:0]         separation;
        logic signed [15:0] music_left;
        logic signed [15:0] music_right;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] frame_left;
        logic signed [15:0] frame_right;
        logic [15:0]        active_mask;
    } out_item_t;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         voice;
        logic [15:0]        address;
        logic signed [15:0] sample_value;
        logic [16:0]        clip_length;
        logic [7:0]         left_gain;
        logic [7:0]         right_gain;
        logic signed [15:0] music_left;
        logic signed [15:0] music_right;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// File: hdl/mssm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module mssm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/mssm_queue.sv
// Short command queue between the front and back parts of the mixer.
// Depends on mssm_pkg for the command and status types.
module mssm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mssm_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output mssm_pkg::cmd_t        head,
    output mssm_pkg::queue_stat_t stat
);

    localparam int PW = $clog2(mssm_pkg::QUEUE_DEPTH);

    mssm_pkg::cmd_t entry_reg [mssm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (PW+1)'(mssm_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// File: hdl/mssm_front.sv
// Front part: accepts requests, drops meaningless ones and works out voice gains.
// Depends on mssm_pkg; feeds mssm_queue.
module mssm_front #(
    parameter int VOICES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mssm_pkg::in_item_t    in_item,
    input  mssm_pkg::queue_stat_t q_stat,
    output logic                  push,
    output mssm_pkg::cmd_t        push_cmd
);

    // Stage A: item and the two gain products.
    logic               a_valid_reg;
    mssm_pkg::in_item_t a_item_reg;
    logic [14:0]        a_lp_reg;
    logic [14:0]        a_rp_reg;
    // Stage B: products and their quotient estimates.
    logic               b_valid_reg;
    mssm_pkg::in_item_t b_item_reg;
    logic [14:0]        b_lp_reg;
    logic [14:0]        b_rp_reg;
    logic [7:0]         b_le_reg;
    logic [7:0]         b_re_reg;

    logic        accept;
    logic        keep;
    logic        a_adv;
    logic        b_free;
    logic [14:0] lp;
    logic [14:0] rp;
    logic [24:0] l_est_full;
    logic [24:0] r_est_full;
    logic [14:0] l_rem;
    logic [14:0] r_rem;
    logic [7:0]  l_gain;
    logic [7:0]  r_gain;

    assign accept = in_valid && in_ready;

    // Keep writes and ticks, and voice requests for voices that exist.
    always_comb
    begin
        case (in_item.req_type)
            mssm_pkg::REQ_WRITE, mssm_pkg::REQ_TICK:
                keep = 1'b1;
            mssm_pkg::REQ_START, mssm_pkg::REQ_STOP, mssm_pkg::REQ_GAIN:
                keep = (7'(in_item.voice) < 7'(VOICES));
            default:
                keep = 1'b0;
        endcase
    end

    // A separation above the right end makes the left product negative; it clamps to 0.
    assign lp = (in_item.separation <= mssm_pkg::SEP_MAX) ?
                15'(mssm_pkg::SEP_MAX - in_item.separation) * 15'(in_item.volume) : '0;
    assign rp = 15'(in_item.separation) * 15'(in_item.volume);

    // x / 127 is x * 258 / 32768, low by at most one; one step corrects it.
    assign l_est_full = 25'(a_lp_reg) * 25'd258;
    assign r_est_full = 25'(a_rp_reg) * 25'd258;

    assign l_rem  = b_lp_reg - ((15'(b_le_reg) << 7) - 15'(b_le_reg));
    assign r_rem  = b_rp_reg - ((15'(b_re_reg) << 7) - 15'(b_re_reg));
    assign l_gain = (l_rem >= 15'd127) ? b_le_reg + 8'd1 : b_le_reg;
    assign r_gain = (r_rem >= 15'd127) ? b_re_reg + 8'd1 : b_re_reg;

    assign push   = b_valid_reg && !q_stat.full;
    assign b_free = !b_valid_reg || push;
    assign a_adv  = a_valid_reg && b_free;
    assign in_ready = !a_valid_reg || b_free;

    always_comb
    begin
        push_cmd.kind         = b_item_reg.req_type;
        push_cmd.voice        = b_item_reg.voice;
        push_cmd.address      = b_item_reg.address;
        push_cmd.sample_value = b_item_reg.sample_value;
        push_cmd.clip_length  = b_item_reg.clip_length;
        push_cmd.left_gain    = l_gain;
        push_cmd.right_gain   = r_gain;
        push_cmd.music_left   = b_item_reg.music_left;
        push_cmd.music_right  = b_item_reg.music_right;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg <= in_item;
            a_lp_reg   <= lp;
            a_rp_reg   <= rp;
        end
        if (a_adv)
        begin
            b_item_reg <= a_item_reg;
            b_lp_reg   <= a_lp_reg;
            b_rp_reg   <= a_rp_reg;
            b_le_reg   <= l_est_full[22:15];
            b_re_reg   <= r_est_full[22:15];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= keep;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/mssm_back.sv
// Back part: voice table, sample memory and the per-frame voice scan.
// Depends on mssm_pkg and mssm_ram; takes commands from mssm_queue.
module mssm_back #(
    parameter int VOICES       = 16,
    parameter int SAMPLE_WORDS = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mssm_pkg::cmd_t        head,
    input  mssm_pkg::queue_stat_t q_stat,
    output logic                  pop,
    input  logic [9:0]            mix_gain,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mssm_pkg::out_item_t   out_item
);

    localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW  = $clog2(SAMPLE_WORDS);
    localparam int SW  = (AW > 18) ? AW : 18;
    localparam int ACW = 20 + $clog2(VOICES + 1);
    localparam int MW  = (VOICES < 16) ? VOICES : 16;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN,
        B_FINISH
    } bstate_t;

    bstate_t                state_reg;
    logic [VW-1:0]          scan_reg;
    logic [15:0]            base_reg   [VOICES];
    logic [16:0]            length_reg [VOICES];
    logic [16:0]            pos_reg    [VOICES];
    logic [7:0]             lg_reg     [VOICES];
    logic [7:0]             rg_reg     [VOICES];
    logic [VOICES-1:0]      active_reg;
    logic                   p1_valid_reg;
    logic [7:0]             p1_lg_reg;
    logic [7:0]             p1_rg_reg;
    logic                   p2_valid_reg;
    logic signed [24:0]     p2_l_reg;
    logic signed [24:0]     p2_r_reg;
    logic signed [ACW-1:0]  acc_l_reg;
    logic signed [ACW-1:0]  acc_r_reg;
    logic signed [26:0]     music_l_reg;
    logic signed [26:0]     music_r_reg;
    logic                   out_valid_reg;
    mssm_pkg::out_item_t    out_item_reg;

    logic [VW-1:0]          cmd_v;
    logic [SW-1:0]          rd_sum;
    logic [SW-1:0]          wr_ext;
    logic [16:0]            pos_inc;
    logic                   ram_we;
    logic [15:0]            rd_data;
    logic signed [ACW-1:0]  fin_l;
    logic signed [ACW-1:0]  fin_r;
    logic                   out_free;
    logic [15:0]            mask;

    assign cmd_v   = VW'(head.voice);
    assign pop     = (state_reg == B_IDLE) && !q_stat.empty;
    assign ram_we  = pop && (head.kind == mssm_pkg::REQ_WRITE);
    assign wr_ext  = SW'(head.address);
    assign rd_sum  = SW'(base_reg[scan_reg]) + SW'(pos_reg[scan_reg]);
    assign pos_inc = pos_reg[scan_reg] + 17'd1;

    mssm_ram #(
        .WIDTH (16),
        .DEPTH (SAMPLE_WORDS)
    ) u_sample_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_ext[AW-1:0]),
        .wr_data (head.sample_value),
        .rd_addr (rd_sum[AW-1:0]),
        .rd_data (rd_data)
    );

    assign fin_l = acc_l_reg + ACW'(music_l_reg >>> 8);
    assign fin_r = acc_r_reg + ACW'(music_r_reg >>> 8);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        mask = '0;
        mask[MW-1:0] = active_reg[MW-1:0];
    end

    always_ff @(posedge clk)
    begin
        p2_l_reg <= $signed(rd_data) * $signed({1'b0, p1_lg_reg});
        p2_r_reg <= $signed(rd_data) * $signed({1'b0, p1_rg_reg});
        p1_lg_reg <= lg_reg[scan_reg];
        p1_rg_reg <= rg_reg[scan_reg];
        if (pop && head.kind == mssm_pkg::REQ_TICK)
        begin
            music_l_reg <= head.music_left * $signed({1'b0, mix_gain});
            music_r_reg <= head.music_right * $signed({1'b0, mix_gain});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            scan_reg      <= '0;
            active_reg    <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            acc_l_reg     <= '0;
            acc_r_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                base_reg[i]   <= '0;
                length_reg[i] <= '0;
                pos_reg[i]    <= '0;
                lg_reg[i]     <= '0;
                rg_reg[i]     <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= p1_valid_reg;
            if (p2_valid_reg)
            begin
                acc_l_reg <= acc_l_reg + ACW'(p2_l_reg >>> 8);
                acc_r_reg <= acc_r_reg + ACW'(p2_r_reg >>> 8);
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        case (head.kind)
                            mssm_pkg::REQ_START:
                            begin
                                base_reg[cmd_v]   <= head.address;
                                length_reg[cmd_v] <= head.clip_length;
                                pos_reg[cmd_v]    <= '0;
                                lg_reg[cmd_v]     <= head.left_gain;
                                rg_reg[cmd_v]     <= head.right_gain;
                                active_reg[cmd_v] <= 1'b1;
                            end
                            mssm_pkg::REQ_STOP:
                            begin
                                active_reg[cmd_v] <= 1'b0;
                            end
                            mssm_pkg::REQ_GAIN:
                            begin
                                lg_reg[cmd_v] <= head.left_gain;
                                rg_reg[cmd_v] <= head.right_gain;
                            end
                            mssm_pkg::REQ_TICK:
                            begin
                                acc_l_reg <= '0;
                                acc_r_reg <= '0;
                                scan_reg  <= '0;
                                state_reg <= B_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                B_SCAN:
                begin
                    if (active_reg[scan_reg])
                    begin
                        p1_valid_reg      <= 1'b1;
                        pos_reg[scan_reg] <= pos_inc;
                        if (pos_inc >= length_reg[scan_reg])
                        begin
                            active_reg[scan_reg] <= 1'b0;
                        end
                    end
                    if (scan_reg == VW'(VOICES - 1))
                    begin
                        state_reg <= B_DRAIN;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                B_DRAIN:
                begin
                    if (!p1_valid_reg && !p2_valid_reg)
                    begin
                        state_reg <= B_FINISH;
                    end
                end
                B_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_item_reg.frame_left <= (fin_l > ACW'(32767)) ? 16'sh7FFF :
                            (fin_l < -ACW'(32768)) ? -16'sh8000 : fin_l[15:0];
                        out_item_reg.frame_right <= (fin_r > ACW'(32767)) ? 16'sh7FFF :
                            (fin_r < -ACW'(32768)) ? -16'sh8000 : fin_r[15:0];
                        out_item_reg.active_mask <= mask;
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: hdl/multichannel_stereo_sample_mixer_core.sv
// Top level of the stereo sample mixer: front part, command queue and back part.
// Depends on mssm_pkg, mssm_front, mssm_queue, mssm_back and the assertion header.
//
// This block mixes up to VOICES playing sample voices and a music stream into stereo
// frames. Requests arrive on the in channel: a sample write stores one signed 16-bit
// word in the sample memory (SAMPLE_WORDS deep, a power of two, addresses wrap), a voice
// start, stop or gain update changes one voice, and a frame tick produces exactly one
// frame on the out channel; no other request gives a result. Requests with an unknown
// type or a voice number of VOICES or more are dropped at the front. The front part
// takes a request every cycle, while the queue has room, into a two-stage pipeline that
// works out the voice gains and then places the request in a four-entry queue, so
// requests keep flowing while the back part is busy. The back part executes one queued
// write, start, stop or gain update per cycle while idle. A frame tick scans the voice
// table one voice per cycle through the single read port of the sample memory, then
// drains its multiply pipeline and adds the music: from the cycle it is taken from the
// queue, a tick holds the back part through the scan, drain and finish states, plus any
// wait for a previous frame still held in the output register. The sample memory has no
// reset and no clearing pass; voices must only play samples already written. The music
// gain register (cfg channel, always ready, reset 256 for unity) saturates at 512 on
// write and must only be written while the block is idle.
`include "multichannel_stereo_sample_mixer_core_assert.svh"

module multichannel_stereo_sample_mixer_core #(
    parameter int VOICES       = 16,
    parameter int SAMPLE_WORDS = 65536
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  mssm_pkg::in_item_t           in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output mssm_pkg::out_item_t          out_item,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [9:0]                   cfg_data
);

    logic [9:0]            music_scale_reg;
    logic                  push;
    logic                  pop;
    mssm_pkg::cmd_t        push_cmd;
    mssm_pkg::cmd_t        head;
    mssm_pkg::queue_stat_t q_stat;

    // The configuration write is always taken; the gain is clamped as it is stored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            music_scale_reg <= mssm_pkg::MUSIC_SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            music_scale_reg <= (cfg_data > mssm_pkg::MUSIC_SCALE_MAX) ?
                               mssm_pkg::MUSIC_SCALE_MAX : cfg_data;
        end
    end

    mssm_front #(
        .VOICES (VOICES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    mssm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    mssm_back #(
        .VOICES       (VOICES),
        .SAMPLE_WORDS (SAMPLE_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .mix_gain   (music_scale_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

    // The stored music gain never exceeds unity times two.
    `MSSM_ASSERT_IMPL(a_gain_range, clk, rst_n, 1'b1,
                      music_scale_reg <= mssm_pkg::MUSIC_SCALE_MAX)
    // The front part never pushes into a full queue.
    `MSSM_ASSERT_IMPL(a_no_overflow, clk, rst_n, q_stat.full, !push)
    // The back part only takes commands that are there.
    `MSSM_ASSERT_IMPL(a_no_underflow, clk, rst_n, q_stat.empty, !pop)
    // A queue both full and empty means the count is corrupt.
    `MSSM_ASSERT_NEXT(a_queue_sane, clk, rst_n, push, !(q_stat.full && q_stat.empty))

endmodule
